/* rtl/xrat_pkg.sv */
package xrat_pkg;
  localparam int unsigned NUM_WIDTH = 32;
  localparam int unsigned MAG_WIDTH = 64;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_NEG  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;
  localparam logic [2:0] MODE_CMP  = 3'd5;
  localparam logic [2:0] MODE_NORM = 3'd6;
  // unused code, answered with a zero-divisor status
  localparam logic [2:0] MODE_BAD  = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  typedef logic [MAG_WIDTH-1:0] mag_t;
  typedef logic [NUM_WIDTH-1:0] num_t;

  // largest positive numerator / denominator and largest negative magnitude
  localparam mag_t POS_LIM = (mag_t'(1) << (NUM_WIDTH - 1)) - mag_t'(1);
  localparam mag_t NEG_LIM = mag_t'(1) << (NUM_WIDTH - 1);

  // clamp a 2-bit mark: -2 reads as -1
  function automatic logic signed [2:0] mark_fn(input logic [1:0] m);
    logic signed [2:0] v;
    v = (m == 2'b10) ? 3'sb111 : {m[1], m};
    return v;
  endfunction

  function automatic logic signed [2:0] sat_fn(input logic signed [2:0] v);
    logic signed [2:0] r;
    if (v > 3'sd1) r = 3'sd1;
    else if (v < -3'sd1) r = -3'sd1;
    else r = v;
    return r;
  endfunction
endpackage

/* rtl/xrat_gcd.sv */
// binary gcd then two shift-subtract divisions, one step per cycle
module xrat_gcd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  xrat_pkg::mag_t    mag_i,
  input  xrat_pkg::mag_t    den_i,
  output logic              done_o,
  output xrat_pkg::mag_t    mag_o,
  output xrat_pkg::mag_t    den_o
);
  localparam logic [2:0] G_IDLE  = 3'd0;
  localparam logic [2:0] G_TWO   = 3'd1;
  localparam logic [2:0] G_XODD  = 3'd2;
  localparam logic [2:0] G_LOOP  = 3'd3;
  localparam logic [2:0] G_DIV   = 3'd4;
  localparam logic [2:0] G_DONE  = 3'd5;
  localparam int unsigned CW = $clog2(xrat_pkg::MAG_WIDTH + 1);

  logic [2:0] state_q, state_d;
  xrat_pkg::mag_t x_q, x_d, y_q, y_d, g_q, g_d;
  xrat_pkg::mag_t n_q, n_d, d_q, d_d;
  xrat_pkg::mag_t quo_q, quo_d, rem_q, rem_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic sel_q, sel_d;
  logic [xrat_pkg::MAG_WIDTH:0] trial;
  xrat_pkg::mag_t dividend;

  assign dividend = sel_q ? d_q : n_q;
  assign trial = {rem_q, dividend[cnt_q[CW-2:0]]} - {1'b0, g_q};

  always_comb begin
    state_d = state_q; x_d = x_q; y_d = y_q; g_d = g_q; n_d = n_q; d_d = d_q;
    quo_d = quo_q; rem_d = rem_q; k_d = k_q; cnt_d = cnt_q; sel_d = sel_q;
    unique case (state_q)
      G_IDLE: if (start_i) begin
        n_d = mag_i; d_d = den_i; x_d = mag_i; y_d = den_i; k_d = '0;
        if (mag_i == '0 || den_i == '0) begin
          g_d = (mag_i == '0) ? den_i : mag_i;
          state_d = (g_d == '0) ? G_DONE : G_DIV;
          if (g_d == '0) begin quo_d = '0; end
        end else begin
          state_d = G_TWO;
        end
        cnt_d = CW'(xrat_pkg::MAG_WIDTH - 1); rem_d = '0; sel_d = 1'b0;
        quo_d = '0;
      end
      G_TWO: if (((x_q | y_q) & 64'd1) == '0) begin
        x_d = x_q >> 1; y_d = y_q >> 1; k_d = k_q + 1'b1;
      end else state_d = G_XODD;
      G_XODD: if (!x_q[0]) x_d = x_q >> 1; else state_d = G_LOOP;
      G_LOOP: if (y_q == '0) begin
        g_d = x_q << k_q; state_d = G_DIV;
      end else if (!y_q[0]) y_d = y_q >> 1;
      else if (x_q > y_q) begin
        x_d = y_q; y_d = x_q - y_q;
      end else y_d = y_q - x_q;
      G_DIV: begin
        if (!trial[xrat_pkg::MAG_WIDTH]) begin
          rem_d = trial[xrat_pkg::MAG_WIDTH-1:0];
          quo_d = {quo_q[xrat_pkg::MAG_WIDTH-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[xrat_pkg::MAG_WIDTH-2:0], dividend[cnt_q[CW-2:0]]};
          quo_d = {quo_q[xrat_pkg::MAG_WIDTH-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          rem_d = '0; cnt_d = CW'(xrat_pkg::MAG_WIDTH - 1);
          if (sel_q) begin d_d = quo_d; state_d = G_DONE; end
          else begin n_d = quo_d; sel_d = 1'b1; quo_d = '0; end
        end else cnt_d = cnt_q - 1'b1;
      end
      G_DONE: state_d = G_IDLE;
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= G_IDLE;
    else state_q <= state_d;
  end
  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; g_q <= g_d; n_q <= n_d; d_q <= d_d;
    quo_q <= quo_d; rem_q <= rem_d; k_q <= k_d; cnt_q <= cnt_d; sel_q <= sel_d;
  end

  assign done_o = (state_q == G_DONE);
  assign mag_o = n_q;
  assign den_o = d_q;
endmodule

/* rtl/extended_rational_alu_core.sv */
// channel | handshake           | payload
// in      | in_valid/in_ready   | mode, a_*, b_*, scalar
// out     | out_valid/out_ready | r_*, less, greater, equal, status
// an item passes the sequencer states (two cross products on the shared multiplier,
// combine), then the binary gcd (data dependent) and two bit-serial shift-subtract
// divisions; the binary gcd and bit-serial quotient loop set the time
// in_ready is high only while idle; one item is in flight at a time
// reset clears the sequencer and the output valid; payload is not reset
// the result waits in the output register until taken; the next item computes
// meanwhile and holds in its last state until the output register is free
module extended_rational_alu_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode_i,
  input  logic signed [xrat_pkg::NUM_WIDTH-1:0] a_num_i,
  input  logic signed [xrat_pkg::NUM_WIDTH-1:0] a_den_i,
  input  logic signed [1:0]  a_eps_i,
  input  logic signed [1:0]  a_inf_i,
  input  logic signed [xrat_pkg::NUM_WIDTH-1:0] b_num_i,
  input  logic [xrat_pkg::NUM_WIDTH-2:0] b_den_i,
  input  logic signed [1:0]  b_eps_i,
  input  logic signed [1:0]  b_inf_i,
  input  logic signed [xrat_pkg::NUM_WIDTH-1:0] scalar_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [xrat_pkg::NUM_WIDTH-1:0] r_num_o,
  output logic [xrat_pkg::NUM_WIDTH-2:0] r_den_o,
  output logic signed [1:0]  r_eps_o,
  output logic signed [1:0]  r_inf_o,
  output logic        less_o,
  output logic        greater_o,
  output logic        equal_o,
  output logic [1:0]  status_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;  // first cross product
  localparam logic [2:0] S_MUL2 = 3'd2;  // second cross product
  localparam logic [2:0] S_COMB = 3'd3;  // combine, launch gcd
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;  // wait for a free output register

  logic [2:0] state_q, state_d;
  logic [2:0] mode_q;
  logic an_q, bn_q;                // signs
  xrat_pkg::num_t am_q, bm_q, ad_q, bd_q, sm_q;
  logic signed [2:0] ae_q, ai_q, be_q, bi_q;
  logic sneg_q, szero_q;
  xrat_pkg::mag_t p_q, q_q;
  xrat_pkg::num_t mul_x, mul_y;
  xrat_pkg::mag_t mul_p;
  logic rneg_q;
  logic signed [2:0] re_q, ri_q;
  logic [1:0] st_q;
  logic lt_q, gt_q, eq_q;
  logic gstart, addsub, out_load;
  xrat_pkg::mag_t gmag, gden, gm, gd;
  logic gdone;
  logic vld_q;
  xrat_pkg::num_t on_q;
  logic [xrat_pkg::NUM_WIDTH-2:0] od_q;
  logic [1:0] oe_q, oi_q, ost_q; logic ol_q, og_q, oq_q;
  xrat_pkg::mag_t smag;
  logic sneg;

  // shared 32x32 multiplier, operands picked by sequencer state
  assign mul_p = xrat_pkg::mag_t'(mul_x) * xrat_pkg::mag_t'(mul_y);
  always_comb begin
    mul_x = am_q; mul_y = bd_q;
    unique case (state_q)
      S_MUL1: if (mode_q == xrat_pkg::MODE_MUL) mul_y = sm_q;
      S_MUL2: begin
        mul_x = (mode_q == xrat_pkg::MODE_DIV) ? ad_q : bm_q;
        mul_y = (mode_q == xrat_pkg::MODE_DIV) ? sm_q : ad_q;
      end
      S_COMB: begin mul_x = ad_q; mul_y = bd_q; end
      default: ;
    endcase
  end

  // signed-magnitude p - or + q
  always_comb begin
    logic n2;
    n2 = (mode_q == xrat_pkg::MODE_ADD) ? bn_q : !bn_q;
    if (an_q == n2) begin sneg = an_q; smag = p_q + q_q; end
    else if (p_q >= q_q) begin sneg = an_q; smag = p_q - q_q; end
    else begin sneg = n2; smag = q_q - p_q; end
    if (smag == '0) sneg = 1'b0;
  end

  // add/sub feed the combined sum and the denominator product straight in
  assign addsub = (mode_q == xrat_pkg::MODE_ADD) || (mode_q == xrat_pkg::MODE_SUB);
  assign gmag = addsub ? smag : p_q;
  assign gden = addsub ? mul_p : q_q;

  xrat_gcd u_gcd (
    .clk_i, .rst_ni, .start_i(gstart),
    .mag_i(gmag), .den_i(gden),
    .done_o(gdone), .mag_o(gm), .den_o(gd)
  );

  assign in_ready = (state_q == S_IDLE);
  assign gstart = (state_q == S_COMB);
  assign out_load = (state_q == S_OUT) && (!vld_q || out_ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid && in_ready) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_COMB;
      S_COMB: state_d = S_GCD;
      S_GCD:  if (gdone) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) vld_q <= 1'b1;
      else if (out_ready) vld_q <= 1'b0;
    end
  end

  // operand capture and datapath
  always_ff @(posedge clk_i) begin
    xrat_pkg::num_t adm, anm, bnm, scm;
    logic flip, ane, zerr, cmp;
    logic signed [2:0] e0, i0, e1, i1;
    logic lt, gt, eq, big;
    unique case (state_q)
      S_IDLE: if (in_valid && in_ready) begin
        anm = a_num_i[xrat_pkg::NUM_WIDTH-1] ? -a_num_i : a_num_i;
        adm = a_den_i[xrat_pkg::NUM_WIDTH-1] ? -a_den_i : a_den_i;
        bnm = b_num_i[xrat_pkg::NUM_WIDTH-1] ? -b_num_i : b_num_i;
        scm = scalar_i[xrat_pkg::NUM_WIDTH-1] ? -scalar_i : scalar_i;
        flip = a_den_i[xrat_pkg::NUM_WIDTH-1];
        // a negative denominator folds into numerator sign and marks
        ane = (anm != '0) && (a_num_i[xrat_pkg::NUM_WIDTH-1] ^ flip);
        e0 = flip ? -xrat_pkg::mark_fn(a_eps_i) : xrat_pkg::mark_fn(a_eps_i);
        i0 = flip ? -xrat_pkg::mark_fn(a_inf_i) : xrat_pkg::mark_fn(a_inf_i);
        sm_q <= scm; sneg_q <= scalar_i[xrat_pkg::NUM_WIDTH-1]; szero_q <= (scalar_i == '0);
        if (mode_i == xrat_pkg::MODE_NEG) begin
          // negate is 0 - A: zero into A, folded A into B; a zero a_den
          // lands in B's denominator and trips the zero check
          mode_q <= xrat_pkg::MODE_SUB;
          am_q <= '0; ad_q <= xrat_pkg::num_t'(1); an_q <= 1'b0; ae_q <= '0; ai_q <= '0;
          bm_q <= anm; bd_q <= adm; bn_q <= ane; be_q <= e0; bi_q <= i0;
        end else begin
          mode_q <= mode_i;
          am_q <= anm; ad_q <= adm; an_q <= ane; ae_q <= e0; ai_q <= i0;
          bm_q <= bnm; bd_q <= {1'b0, b_den_i};
          bn_q <= (bnm != '0) && b_num_i[xrat_pkg::NUM_WIDTH-1];
          be_q <= xrat_pkg::mark_fn(b_eps_i); bi_q <= xrat_pkg::mark_fn(b_inf_i);
        end
      end
      S_MUL1: begin
        unique case (mode_q)
          xrat_pkg::MODE_DIV, xrat_pkg::MODE_NORM: p_q <= xrat_pkg::mag_t'(am_q);
          default: p_q <= mul_p;
        endcase
      end
      S_MUL2: begin
        unique case (mode_q)
          xrat_pkg::MODE_MUL, xrat_pkg::MODE_NORM: q_q <= xrat_pkg::mag_t'(ad_q);
          default: q_q <= mul_p;
        endcase
      end
      S_COMB: begin
        zerr = (ad_q == '0) || (mode_q == xrat_pkg::MODE_BAD)
            || (mode_q == xrat_pkg::MODE_DIV && szero_q)
            || ((mode_q == xrat_pkg::MODE_ADD || mode_q == xrat_pkg::MODE_SUB
                 || mode_q == xrat_pkg::MODE_CMP) && bd_q == '0);
        cmp = (mode_q == xrat_pkg::MODE_CMP);
        lt = 1'b0; gt = 1'b0; eq = 1'b0;
        if (ai_q == '0 && bi_q == '0) begin
          lt = (smag != '0 && sneg) || (smag == '0 && ae_q < be_q);
          gt = (smag != '0 && !sneg) || (smag == '0 && ae_q > be_q);
          eq = an_q == bn_q && am_q == bm_q && ad_q == bd_q && ae_q == be_q;
        end else begin
          lt = ai_q < bi_q; gt = ai_q > bi_q; eq = (ai_q != '0) && (ai_q == bi_q);
        end
        lt_q <= cmp && !zerr && lt; gt_q <= cmp && !zerr && gt; eq_q <= cmp && !zerr && eq;
        st_q <= zerr ? xrat_pkg::ST_ZERO : xrat_pkg::ST_OK;
        unique case (mode_q)
          xrat_pkg::MODE_ADD, xrat_pkg::MODE_SUB: begin
            rneg_q <= sneg;
            e1 = (mode_q == xrat_pkg::MODE_SUB) ? ae_q - be_q : ae_q + be_q;
            i1 = (mode_q == xrat_pkg::MODE_SUB) ? ai_q - bi_q : ai_q + bi_q;
            re_q <= xrat_pkg::sat_fn(e1); ri_q <= xrat_pkg::sat_fn(i1);
          end
          xrat_pkg::MODE_MUL: begin
            rneg_q <= sneg_q ? !an_q : an_q;
            re_q <= sneg_q ? -ae_q : (szero_q ? 3'sd0 : ae_q);
            ri_q <= sneg_q ? -ai_q : (szero_q ? 3'sd0 : ai_q);
          end
          xrat_pkg::MODE_DIV: begin
            rneg_q <= sneg_q ? !an_q : an_q;
            re_q <= sneg_q ? -ae_q : ae_q; ri_q <= sneg_q ? -ai_q : ai_q;
          end
          default: begin rneg_q <= an_q; re_q <= ae_q; ri_q <= ai_q; end
        endcase
      end
      S_OUT: if (out_load) begin
        // gcd results hold steady until the next start
        big = (gd > xrat_pkg::POS_LIM) ||
              ((rneg_q && gm != '0) ? gm > xrat_pkg::NEG_LIM : gm > xrat_pkg::POS_LIM);
        ol_q <= lt_q; og_q <= gt_q; oq_q <= eq_q;
        ost_q <= (st_q == xrat_pkg::ST_OK && big && mode_q != xrat_pkg::MODE_CMP)
                 ? xrat_pkg::ST_RANGE : st_q;
        if (st_q != xrat_pkg::ST_OK || mode_q == xrat_pkg::MODE_CMP || big) begin
          on_q <= '0; od_q <= '0; oe_q <= '0; oi_q <= '0;
        end else begin
          on_q <= (rneg_q && gm != '0) ? -gm[xrat_pkg::NUM_WIDTH-1:0]
                                       : gm[xrat_pkg::NUM_WIDTH-1:0];
          od_q <= gd[xrat_pkg::NUM_WIDTH-2:0]; oe_q <= re_q[1:0]; oi_q <= ri_q[1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid = vld_q;
  assign r_num_o = on_q;
  assign r_den_o = od_q;
  assign r_eps_o = oe_q;
  assign r_inf_o = oi_q;
  assign less_o = ol_q;
  assign greater_o = og_q;
  assign equal_o = oq_q;
  assign status_o = ost_q;
endmodule
